// ===== src/bsa_pkg.sv =====
package bsa_pkg;

   localparam int MAX_SLOTS = 256;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int ROW_BITS  = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
   localparam int ROWS      = MAX_SLOTS / ROW_BITS;
   localparam int COL_W     = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int STEP_W    = $clog2(IDX_W + 1);

   localparam int SIZE_W    = 16;
   localparam int LIMIT_W   = 9;
   localparam int ADDR_W    = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_SLOT_BYTES   = 2'd0;
   localparam logic [1:0] REG_SLOT_LIMIT   = 2'd1;
   localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SIZE    = 3'd1,
      ST_OOM     = 3'd2,
      ST_NULL    = 3'd3,
      ST_BADFREE = 3'd4
   } status_type;

   typedef struct packed {
      logic                clear;
      logic                rd_en;
      logic [ROW_W-1:0]    rd_row;
      logic                wr_en;
      logic [ROW_W-1:0]    wr_row;
      logic [ROW_BITS-1:0] wr_data;
   } map_cmd_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] rd_data;
      logic [ROWS-1:0]     row_full;
   } map_stat_type;

   typedef struct packed {
      logic             done;
      logic             over;
      logic [IDX_W-1:0] quot;
   } div_result_type;

endpackage

// ===== src/bsa_channels.sv =====
interface bsa_req_if;
   import bsa_pkg::*;

   logic                valid;
   logic                ready;
   logic                op;
   logic [SIZE_W-1:0]   request_size;
   logic [ADDR_W-1:0]   free_address;

   modport source (output valid, output op, output request_size, output free_address,
                   input ready);
   modport sink   (input valid, input op, input request_size, input free_address,
                   output ready);
endinterface

interface bsa_rsp_if;
   import bsa_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic [ADDR_W-1:0]   slot_address;
   logic [IDX_W-1:0]    slot_index;
   logic [CNT_W-1:0]    live_count;

   modport source (output valid, output status, output slot_address, output slot_index,
                   output live_count, input ready);
   modport sink   (input valid, input status, input slot_address, input slot_index,
                   input live_count, output ready);
endinterface

// ===== src/bitmap_slot_allocator.sv =====
// Fixed-size slot allocator. Software programs the slot size, the slot limit and the
// base address over the APB port; any register write empties the pool. Each request
// transfer yields exactly one response transfer. An accepted allocate passes through
// a check step that also reads an occupancy row of the bitmap memory, a step that
// writes the modified row back, a step for the index times size product, one for the
// address add, and the hand-off into the response register. A free that reaches the
// divider passes through the check step, the iterative divider that turns the address
// offset into a slot index one bit per cycle, a step that takes the quotient and reads
// the row, the row write-back, and the hand-off. A free whose quotient cannot be a slot
// goes from the divider straight to the hand-off, and a request rejected by the check
// step (size mismatch, out of memory, null or invalid free) goes from there straight
// to the hand-off. The hand-off waits while the response register still holds a result
// that the consumer has not taken. The bitmap is kept in rows of 32 bits; per-row valid
// flags make reset and register writes empty the pool at once, so no clearing pass is
// needed. The next request is taken as soon as the previous result sits in the response
// register, even if that result has not yet been taken by the consumer.
module bitmap_slot_allocator (
   input  logic                            clock,
   input  logic                            reset,
   bsa_req_if.sink                         req_bus,
   bsa_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import bsa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_ALLOC_WR, S_ALLOC_MUL, S_ALLOC_ADD, S_DIV, S_FREE_WR, S_DONE
   } state_type;

   state_type               state_ff, state_in;

   // Configuration registers.
   logic [SIZE_W-1:0]       slot_bytes_ff, slot_bytes_in;
   logic [LIMIT_W-1:0]      slot_limit_ff, slot_limit_in;
   logic [ADDR_W-1:0]       base_ff, base_in;

   // Pool count and the request being worked on.
   logic [CNT_W-1:0]        used_ff, used_in;
   logic                    op_ff, op_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [ADDR_W-1:0]       faddr_ff, faddr_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W+SIZE_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   status_type              status_ff, status_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                    cfg_wr;
   logic [1:0]              cfg_sel;
   logic [CNT_W-1:0]        lim_eff;
   logic [ROW_W-1:0]        free_row;
   logic [COL_W-1:0]        free_col;
   logic [ROW_BITS-1:0]     alloc_bit;
   logic [ROW_BITS-1:0]     release_bit;

   map_cmd_type             map_cmd;
   map_stat_type            map_stat;
   logic                    div_start;
   div_result_type          div_res;

   bsa_map_store u_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .stat  (map_stat)
   );

   bsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (faddr_ff - base_ff),
      .divisor  (slot_bytes_ff),
      .result   (div_res)
   );

   // APB: no wait states; registers read back as written, cut to their field widths.
   assign pready  = 1'b1;
   assign cfg_sel = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      case (cfg_sel)
         REG_SLOT_BYTES:   prdata = 32'(slot_bytes_ff);
         REG_SLOT_LIMIT:   prdata = 32'(slot_limit_ff);
         REG_BASE_ADDRESS: prdata = base_ff;
         default:          prdata = '0;
      endcase
   end

   // A limit above the built capacity behaves as the capacity.
   assign lim_eff = (32'(slot_limit_ff) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                          : CNT_W'(slot_limit_ff);

   // Lowest row that still has a free slot, and the lowest free bit in the row read back.
   always_comb begin
      free_row = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!map_stat.row_full[r]) begin
            free_row = ROW_W'(r);
         end
      end
   end

   always_comb begin
      free_col = '0;
      for (int c = ROW_BITS - 1; c >= 0; c--) begin
         if (!map_stat.rd_data[c]) begin
            free_col = COL_W'(c);
         end
      end
   end

   assign alloc_bit   = ROW_BITS'(1) << free_col;
   assign release_bit = ROW_BITS'(1) << idx_ff[COL_W-1:0];

   always_comb begin
      state_in      = state_ff;
      slot_bytes_in = slot_bytes_ff;
      slot_limit_in = slot_limit_ff;
      base_in       = base_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      map_cmd       = '0;
      div_start     = 1'b0;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.op;
               size_in  = req_bus.request_size;
               faddr_in = req_bus.free_address;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (op_ff == OP_ALLOC) begin
               if (slot_bytes_ff == '0 || size_ff != slot_bytes_ff) begin
                  status_in = ST_SIZE;
                  state_in  = S_DONE;
               end else if (used_ff >= lim_eff) begin
                  status_in = ST_OOM;
                  state_in  = S_DONE;
               end else begin
                  // Slots at or above the limit are never marked, so the lowest free
                  // slot of the whole map lies below the limit here.
                  map_cmd.rd_en  = 1'b1;
                  map_cmd.rd_row = free_row;
                  row_in         = free_row;
                  state_in       = S_ALLOC_WR;
               end
            end else begin
               if (faddr_ff == '0) begin
                  status_in = ST_NULL;
                  state_in  = S_DONE;
               end else if (slot_bytes_ff == '0 || faddr_ff < base_ff) begin
                  status_in = ST_BADFREE;
                  state_in  = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_ALLOC_WR: begin
            map_cmd.wr_en   = 1'b1;
            map_cmd.wr_row  = row_ff;
            map_cmd.wr_data = map_stat.rd_data | alloc_bit;
            idx_in          = {row_ff, free_col};
            used_in         = used_ff + CNT_W'(1);
            status_in       = ST_OK;
            state_in        = S_ALLOC_MUL;
         end
         S_ALLOC_MUL: begin
            prod_in  = idx_ff * slot_bytes_ff;
            state_in = S_ALLOC_ADD;
         end
         S_ALLOC_ADD: begin
            addr_in  = base_ff + ADDR_W'(prod_ff);
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_res.done) begin
               if (div_res.over || CNT_W'(div_res.quot) >= lim_eff) begin
                  status_in = ST_BADFREE;
                  state_in  = S_DONE;
               end else begin
                  map_cmd.rd_en  = 1'b1;
                  map_cmd.rd_row = div_res.quot[IDX_W-1:COL_W];
                  idx_in         = div_res.quot;
                  state_in       = S_FREE_WR;
               end
            end
         end
         S_FREE_WR: begin
            if (!map_stat.rd_data[idx_ff[COL_W-1:0]]) begin
               status_in = ST_BADFREE;
            end else begin
               map_cmd.wr_en   = 1'b1;
               map_cmd.wr_row  = idx_ff[IDX_W-1:COL_W];
               map_cmd.wr_data = map_stat.rd_data & ~release_bit;
               if (used_ff != '0) begin
                  used_in = used_ff - CNT_W'(1);
               end
               status_in = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result over once the response register is free or being emptied.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = (status_ff == ST_OK) ? idx_ff : '0;
               rsp_addr_in   = (status_ff == ST_OK && op_ff == OP_ALLOC) ? addr_ff : '0;
               rsp_count_in  = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Do register writes in idle only (unchecked by the block); each empties the pool.
      if (cfg_wr) begin
         case (cfg_sel)
            REG_SLOT_BYTES:   slot_bytes_in = pwdata[SIZE_W-1:0];
            REG_SLOT_LIMIT:   slot_limit_in = pwdata[LIMIT_W-1:0];
            REG_BASE_ADDRESS: base_in       = pwdata[ADDR_W-1:0];
            default:          ;
         endcase
         if (cfg_sel == REG_SLOT_BYTES || cfg_sel == REG_SLOT_LIMIT ||
             cfg_sel == REG_BASE_ADDRESS) begin
            map_cmd.clear = 1'b1;
            used_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_bytes_ff <= SIZE_W'(1);
         slot_limit_ff <= '0;
         base_ff       <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_bytes_ff <= slot_bytes_in;
         slot_limit_ff <= slot_limit_in;
         base_ff       <= base_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_ff         <= op_in;
         size_ff       <= size_in;
         faddr_ff      <= faddr_in;
         row_ff        <= row_in;
         idx_ff        <= idx_in;
         prod_ff       <= prod_in;
         addr_ff       <= addr_in;
         status_ff     <= status_in;
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.slot_address = rsp_addr_ff;
   assign rsp_bus.slot_index   = rsp_index_ff;
   assign rsp_bus.live_count   = rsp_count_ff;

   // The row picked for an allocation must really hold a free slot.
   a_alloc_row_has_space: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_WR |-> map_stat.rd_data != '1)
      else $error("allocation row read back full");

   // A successful allocation raises the live count by exactly one.
   a_alloc_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_WR |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("live count did not follow allocation");

   // The live count never passes the effective limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= lim_eff)
      else $error("live count above slot limit");

   // Failed requests report neither a slot nor an address.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_index_ff == '0 && rsp_addr_ff == '0)
      else $error("failed request carries slot data");

   // An accepted request always starts with the check cycle.
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == S_CHECK)
      else $error("accepted request not checked");

endmodule

// ===== src/bsa_map_store.sv =====
module bsa_map_store (
   input  logic                  clock,
   input  logic                  reset,
   input  bsa_pkg::map_cmd_type  cmd,
   output bsa_pkg::map_stat_type stat
);
   import bsa_pkg::*;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]     row_valid_ff;
   logic [ROWS-1:0]     row_full_ff;
   logic [ROW_BITS-1:0] rd_q_ff;
   logic                rd_vld_ff;

   // Occupancy rows; a row that was never written since the last clear reads as all free.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_row] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[cmd.rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_valid_ff <= '0;
         row_full_ff  <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            row_valid_ff[cmd.wr_row] <= 1'b1;
            row_full_ff[cmd.wr_row]  <= &cmd.wr_data;
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= row_valid_ff[cmd.rd_row];
         end
      end
   end

   assign stat.rd_data  = rd_vld_ff ? rd_q_ff : '0;
   assign stat.row_full = row_full_ff;

endmodule

// ===== src/bsa_divider.sv =====
module bsa_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bsa_pkg::ADDR_W-1:0]  dividend,
   input  logic [bsa_pkg::SIZE_W-1:0]  divisor,
   output bsa_pkg::div_result_type     result
);
   import bsa_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type                state_ff, state_in;
   logic [ADDR_W-1:0]         rem_ff, rem_in;
   logic [SIZE_W+IDX_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [IDX_W-1:0]          quot_ff, quot_in;
   logic                      done_ff, done_in;
   logic                      over_ff, over_in;
   logic                      ge;

   // Restoring division, one quotient bit a cycle. The first compare against the
   // divisor shifted by the full index width flags quotients that cannot be a slot.
   assign ge = rem_ff >= ADDR_W'(div_ff);

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      over_in  = over_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = dividend;
               div_in   = {divisor, {IDX_W{1'b0}}};
               step_in  = STEP_W'(IDX_W);
               quot_in  = '0;
               over_in  = 1'b0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (step_ff == STEP_W'(IDX_W)) begin
               if (ge) begin
                  over_in  = 1'b1;
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end else begin
                  div_in  = div_ff >> 1;
                  step_in = step_ff - STEP_W'(1);
               end
            end else begin
               if (ge) begin
                  rem_in = rem_ff - ADDR_W'(div_ff);
               end
               quot_in = {quot_ff[IDX_W-2:0], ge};
               div_in  = div_ff >> 1;
               step_in = step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         rem_ff   <= rem_in;
         div_ff   <= div_in;
         step_ff  <= step_in;
         quot_ff  <= quot_in;
         over_ff  <= over_in;
      end
   end

   assign result.done = done_ff;
   assign result.over = over_ff;
   assign result.quot = quot_ff;

endmodule
